FILE: rtl/clcd_pkg.sv
`default_nettype none

package clcd_pkg;

   localparam int CountWidthDefault = 16;
   localparam int CfgWidth          = 16;
   localparam int CfgIndexWidth     = 3;
   localparam int QueueDepth        = 2;

   localparam logic [CfgIndexWidth-1:0] CFG_HOLD     = 3'd0;
   localparam logic [CfgIndexWidth-1:0] CFG_POWERUP  = 3'd1;
   localparam logic [CfgIndexWidth-1:0] CFG_WAKE     = 3'd2;
   localparam logic [CfgIndexWidth-1:0] CFG_SETTLE   = 3'd3;
   localparam logic [CfgIndexWidth-1:0] CFG_INIT_GAP = 3'd4;

   localparam logic [CfgWidth-1:0] HOLD_RESET     = 16'd2;
   localparam logic [CfgWidth-1:0] POWERUP_RESET  = 16'd40;
   localparam logic [CfgWidth-1:0] WAKE_RESET     = 16'd5;
   localparam logic [CfgWidth-1:0] SETTLE_RESET   = 16'd2;
   localparam logic [CfgWidth-1:0] INIT_GAP_RESET = 16'd50;

   localparam logic [3:0] NIB_WAKE  = 4'h3;
   localparam logic [3:0] NIB_4BIT  = 4'h2;
   localparam logic [2:0] SETUP_LAST = 3'd5;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_INSTR = 2'd1;
   localparam logic [1:0] CMD_CHAR  = 2'd2;
   localparam logic [1:0] CMD_INIT  = 2'd3;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_BYTE,
      OP_INIT
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SETUP,
      PH_HI,
      PH_MID,
      PH_LO,
      PH_GAP,
      PH_WAIT0,
      PH_STB0,
      PH_WAIT1,
      PH_STB1,
      PH_WAIT2,
      PH_STB2,
      PH_WAIT3,
      PH_STB3
   } phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic       read_write;
      logic       enable_pin;
      logic [3:0] bus_nibble;
      logic       busy_res;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [CfgWidth-1:0] hold_ticks;
      logic [CfgWidth-1:0] powerup_ticks;
      logic [CfgWidth-1:0] wake_ticks;
      logic [CfgWidth-1:0] settle_ticks;
      logic [CfgWidth-1:0] init_gap_ticks;
   } cfg_type;

   // one queued step: what the front decided the beat asks for
   typedef struct packed {
      kind_type   kind;
      logic       rs;
      logic       request;
      logic [7:0] value;
   } entry_type;

   function automatic logic [7:0] setup_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h28;
         3'd1:    b = 8'h0E;
         3'd2:    b = 8'h01;
         3'd3:    b = 8'h06;
         3'd4:    b = 8'h80;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/clcd_front.sv
`default_nettype none

module clcd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire clcd_pkg::req_type  req_data,
   output logic                    q_valid,
   input  wire logic               q_pop,
   output clcd_pkg::entry_type     q_entry
);
   import clcd_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);

   entry_type             slot_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   entry_type             classified;
   logic                  push;

   always_comb begin
      classified.value   = req_data.value;
      classified.rs      = (req_data.command == CMD_CHAR);
      classified.request = (req_data.command != CMD_TICK);
      unique case (req_data.command)
         CMD_TICK:  classified.kind = OP_TICK;
         CMD_INSTR: classified.kind = OP_BYTE;
         CMD_CHAR:  classified.kind = OP_BYTE;
         CMD_INIT:  classified.kind = OP_INIT;
         default:   classified.kind = OP_TICK;
      endcase
   end

   assign req_stall = (count_ff == CntWidth'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/clcd_back.sv
`default_nettype none

module clcd_back #(
   parameter int COUNT_WIDTH = clcd_pkg::CountWidthDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire clcd_pkg::cfg_type   cfg,
   input  wire logic                q_valid,
   output logic                     q_pop,
   input  wire clcd_pkg::entry_type q_entry,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output clcd_pkg::rsp_type        rsp_data
);
   import clcd_pkg::*;

   localparam logic [32:0] CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [7:0]             byte_ff, byte_in;
   logic [2:0]             init_step_ff, init_step_in;
   logic                   rs_ff, rs_in;
   logic                   en_ff, en_in;
   logic [3:0]             nib_ff, nib_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   step;
   logic                   busy;

   // zero means one tick; long waits saturate at the counter's range
   function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [CfgWidth-1:0] ticks);
      logic [32:0] d;
      d = (ticks == '0) ? 33'd0 : 33'(ticks) - 33'd1;
      if (d > CountMax) begin
         d = CountMax;
      end
      return d[COUNT_WIDTH-1:0];
   endfunction

   assign step  = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = step;
   assign busy  = (phase_ff != PH_IDLE);

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      byte_in      = byte_ff;
      init_step_in = init_step_ff;
      rs_in        = rs_ff;
      en_in        = en_ff;
      nib_in       = nib_ff;
      if (step) begin
         if (busy) begin
            if (tick_ff != '0) begin
               tick_in = tick_ff - 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_SETUP: begin
                     phase_in = PH_HI;
                     tick_in  = load_count(cfg.hold_ticks);
                     en_in    = 1'b1;
                  end
                  PH_HI: begin
                     nib_in   = byte_ff[3:0];
                     phase_in = PH_MID;
                     tick_in  = '0;
                     en_in    = 1'b0;
                  end
                  PH_MID: begin
                     phase_in = PH_LO;
                     tick_in  = load_count(cfg.hold_ticks);
                     en_in    = 1'b1;
                  end
                  PH_LO: begin
                     en_in = 1'b0;
                     if (init_step_ff == '0) begin
                        phase_in = PH_IDLE;
                        tick_in  = '0;
                     end else begin
                        phase_in = PH_GAP;
                        tick_in  = load_count(cfg.init_gap_ticks);
                     end
                  end
                  PH_GAP: begin
                     en_in   = 1'b0;
                     tick_in = '0;
                     if (init_step_ff != '0 && init_step_ff < SETUP_LAST) begin
                        byte_in      = setup_byte(init_step_ff);
                        rs_in        = 1'b0;
                        nib_in       = byte_in[7:4];
                        phase_in     = PH_SETUP;
                        init_step_in = init_step_ff + 1'b1;
                     end else begin
                        init_step_in = '0;
                        phase_in     = PH_IDLE;
                     end
                  end
                  PH_WAIT0: begin
                     phase_in = PH_STB0;
                     tick_in  = '0;
                     en_in    = 1'b1;
                  end
                  PH_STB0: begin
                     phase_in = PH_WAIT1;
                     tick_in  = load_count(cfg.wake_ticks);
                     en_in    = 1'b0;
                  end
                  PH_WAIT1: begin
                     phase_in = PH_STB1;
                     tick_in  = '0;
                     en_in    = 1'b1;
                  end
                  PH_STB1: begin
                     phase_in = PH_WAIT2;
                     tick_in  = load_count(cfg.wake_ticks);
                     en_in    = 1'b0;
                  end
                  PH_WAIT2: begin
                     phase_in = PH_STB2;
                     tick_in  = '0;
                     en_in    = 1'b1;
                  end
                  PH_STB2: begin
                     nib_in   = NIB_4BIT;
                     phase_in = PH_WAIT3;
                     tick_in  = load_count(cfg.settle_ticks);
                     en_in    = 1'b0;
                  end
                  PH_WAIT3: begin
                     phase_in = PH_STB3;
                     tick_in  = '0;
                     en_in    = 1'b1;
                  end
                  PH_STB3: begin
                     byte_in      = setup_byte(3'd0);
                     rs_in        = 1'b0;
                     nib_in       = byte_in[7:4];
                     phase_in     = PH_SETUP;
                     tick_in      = '0;
                     en_in        = 1'b0;
                     init_step_in = 3'd1;
                  end
                  default: begin
                     init_step_in = '0;
                     phase_in     = PH_IDLE;
                     tick_in      = '0;
                     en_in        = 1'b0;
                  end
               endcase
            end
         end else begin
            unique case (q_entry.kind)
               OP_BYTE: begin
                  init_step_in = '0;
                  byte_in      = q_entry.value;
                  rs_in        = q_entry.rs;
                  nib_in       = q_entry.value[7:4];
                  phase_in     = PH_SETUP;
                  tick_in      = '0;
                  en_in        = 1'b0;
               end
               OP_INIT: begin
                  init_step_in = '0;
                  rs_in        = 1'b0;
                  nib_in       = NIB_WAKE;
                  phase_in     = PH_WAIT0;
                  tick_in      = load_count(cfg.powerup_ticks);
                  en_in        = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end

      rsp_data_in.reg_select = rs_in;
      rsp_data_in.read_write = 1'b0;
      rsp_data_in.enable_pin = en_in;
      rsp_data_in.bus_nibble = nib_in;
      rsp_data_in.busy_res   = (phase_in != PH_IDLE);
      rsp_data_in.rejected   = busy && q_entry.request;

      rsp_valid_in = step || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         byte_ff      <= '0;
         init_step_ff <= '0;
         rs_ff        <= 1'b0;
         en_ff        <= 1'b0;
         nib_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         byte_ff      <= byte_in;
         init_step_ff <= init_step_in;
         rs_ff        <= rs_in;
         en_ff        <= en_in;
         nib_ff       <= nib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_idle_no_init: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> init_step_ff == '0)
      else $error("init step left set while idle");

   a_enable_phase: assert property (@(posedge clock) disable iff (reset)
      en_ff |-> (phase_ff == PH_HI || phase_ff == PH_LO || phase_ff == PH_STB0 ||
                 phase_ff == PH_STB1 || phase_ff == PH_STB2 || phase_ff == PH_STB3))
      else $error("enable high outside a strobe phase");

   a_countdown_holds: assert property (@(posedge clock) disable iff (reset)
      step && busy && tick_ff != '0 |=> $stable(phase_ff))
      else $error("phase moved before its count ran out");

   a_init_start: assert property (@(posedge clock) disable iff (reset)
      step && !busy && q_entry.kind == OP_INIT |=> phase_ff == PH_WAIT0 && nib_ff == NIB_WAKE)
      else $error("initialization did not start with the wake nibble");

   a_no_step_frozen: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("state advanced without a beat");
`endif

endmodule

`default_nettype wire

FILE: rtl/char_lcd_nibble_interface.sv
// Character LCD driver for a 4-bit bus.
// Input channel (req_*): one beat per tick. command selects tick only, an
// instruction byte, a character byte or the power-up initialization; value
// carries the byte. Every accepted beat yields exactly one rsp_* beat with
// the pin levels after that tick, busy_res and a rejected flag for requests
// that arrive while a write or initialization is still running.
// Throughput: one beat per clock in both directions while neither side
// stalls. An accepted beat passes the queue and then the result register.
// A two-entry queue parts the request side from the sequencer, and the
// sequencer writes into a result register, so either side can stall
// without stopping the other until the queue fills or runs empty;
// req_stall is high only while the queue is full. While rsp_stall is
// high and a result is valid, the result holds and the sequencer waits.
// csr_* writes the five timing registers (hold, power-up, wake, settle,
// init gap); write them only while the block is idle.
// Reset (synchronous) empties the queue, idles the sequencer with its pin
// state low (not rsp_data itself) and sets the timing register defaults.
`default_nettype none

module char_lcd_nibble_interface #(
   parameter int COUNT_WIDTH = clcd_pkg::CountWidthDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire clcd_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output clcd_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_write,
   input  wire logic [clcd_pkg::CfgIndexWidth-1:0]  csr_index,
   input  wire logic [clcd_pkg::CfgWidth-1:0]       csr_wdata
);
   import clcd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CFG_HOLD:     cfg_in.hold_ticks     = csr_wdata;
            CFG_POWERUP:  cfg_in.powerup_ticks  = csr_wdata;
            CFG_WAKE:     cfg_in.wake_ticks     = csr_wdata;
            CFG_SETTLE:   cfg_in.settle_ticks   = csr_wdata;
            CFG_INIT_GAP: cfg_in.init_gap_ticks = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks     <= HOLD_RESET;
         cfg_ff.powerup_ticks  <= POWERUP_RESET;
         cfg_ff.wake_ticks     <= WAKE_RESET;
         cfg_ff.settle_ticks   <= SETTLE_RESET;
         cfg_ff.init_gap_ticks <= INIT_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_entry   (q_entry)
   );

   clcd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_entry   (q_entry),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
